// ===== rtl/core/sip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the SipHash keyed hash block.
// No dependencies; used by every module of the block.
package sip_pkg;

  // Initialisation constants of the four state words
  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

  // Field widths
  localparam int WordW  = 64;
  localparam int ByteW  = 8;
  localparam int RoundW = 4;
  localparam int CntW   = RoundW + 1;  // half-round counter, up to twice the round count

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_KEY_LOW   = 2'd0,
    REG_KEY_HIGH  = 2'd1,
    REG_COMP_RNDS = 2'd2,
    REG_FIN_RNDS  = 2'd3
  } sip_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_COMP_END,
    S_FINAL_LOAD,
    S_FIN,
    S_HASH
  } sip_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // take the input byte
    logic half_round;  // run one half of a SipRound
    logic half_sel;    // 0: first half, 1: second half
    logic absorb_end;  // v0 ^= m
    logic final_xor;   // v2 ^= 0xff
    logic final_load;  // build final word and xor it into v3
    logic hash_load;   // capture hash and close the message
  } sip_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic word_full;   // input byte completes a word
    logic end_msg;     // input item closes the message
  } sip_status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int b);
    return (x << b) | (x >> (64 - b));
  endfunction

endpackage

// ===== rtl/core/sip_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller for the SipHash block: item acceptance, round
// counting and output register handshake. Depends on sip_pkg.
module sip_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  output logic                       s_ready,
  output logic                       m_valid,
  input  logic                       m_ready,
  input  logic [sip_pkg::RoundW-1:0] comp_rounds,
  input  logic [sip_pkg::RoundW-1:0] fin_rounds,
  input  sip_pkg::sip_status_t       status,
  output sip_pkg::sip_cmd_t          cmd
);

  sip_pkg::sip_state_t state, state_next;
  logic [sip_pkg::CntW-1:0] cnt, cnt_next;
  logic final_word, final_word_next;
  logic closing, closing_next;
  logic out_valid, out_valid_next;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sip_pkg::S_IDLE;
      cnt        <= '0;
      final_word <= 1'b0;
      closing    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      final_word <= final_word_next;
      closing    <= closing_next;
      out_valid  <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    final_word_next = final_word;
    closing_next    = closing;
    cmd             = '0;
    s_ready         = 1'b0;

    case (state)
      sip_pkg::S_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.accept   = 1'b1;
          closing_next = status.end_msg;
          if (status.word_full) begin
            cnt_next        = {comp_rounds, 1'b0};
            final_word_next = 1'b0;
            state_next      = sip_pkg::S_COMP;
          end else if (status.end_msg) begin
            state_next = sip_pkg::S_FINAL_LOAD;
          end
        end
      end
      sip_pkg::S_COMP: begin
        // one half-round per cycle; a zero count passes straight through
        if (cnt != '0) begin
          cmd.half_round = 1'b1;
          cmd.half_sel   = cnt[0];
          cnt_next       = cnt - 1'b1;
        end
        if (cnt[sip_pkg::CntW-1:1] == '0) begin
          state_next = sip_pkg::S_COMP_END;
        end
      end
      sip_pkg::S_COMP_END: begin
        cmd.absorb_end = 1'b1;
        if (final_word) begin
          cmd.final_xor = 1'b1;
          cnt_next      = {fin_rounds, 1'b0};
          state_next    = sip_pkg::S_FIN;
        end else if (closing) begin
          state_next = sip_pkg::S_FINAL_LOAD;
        end else begin
          state_next = sip_pkg::S_IDLE;
        end
      end
      sip_pkg::S_FINAL_LOAD: begin
        cmd.final_load  = 1'b1;
        cnt_next        = {comp_rounds, 1'b0};
        final_word_next = 1'b1;
        state_next      = sip_pkg::S_COMP;
      end
      sip_pkg::S_FIN: begin
        if (cnt != '0) begin
          cmd.half_round = 1'b1;
          cmd.half_sel   = cnt[0];
          cnt_next       = cnt - 1'b1;
        end
        if (cnt[sip_pkg::CntW-1:1] == '0) begin
          state_next = sip_pkg::S_HASH;
        end
      end
      sip_pkg::S_HASH: begin
        // wait for the output register to free up
        if (!out_valid || m_ready) begin
          cmd.hash_load   = 1'b1;
          final_word_next = 1'b0;
          closing_next    = 1'b0;
          state_next      = sip_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sip_pkg::S_IDLE;
      end
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_valid_next = cmd.hash_load | (out_valid & ~m_ready);
  end

  assign m_valid = out_valid;

endmodule

// ===== rtl/core/sip_datapath.sv =====
`timescale 1ns / 1ps
// SipHash datapath: state words, byte packing, length count, half-round
// mixing unit and hash output register. Depends on sip_pkg.
module sip_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  sip_pkg::sip_cmd_t         cmd,
  input  logic [sip_pkg::ByteW-1:0] message_byte,
  input  logic                      byte_present,
  input  logic                      end_of_message,
  input  logic [sip_pkg::WordW-1:0] key_low,
  input  logic [sip_pkg::WordW-1:0] key_high,
  output sip_pkg::sip_status_t      status,
  output logic [sip_pkg::WordW-1:0] hash_value
);

  logic [sip_pkg::WordW-1:0] v0, v1, v2, v3;
  logic [sip_pkg::WordW-1:0] v0_next, v1_next, v2_next, v3_next;
  logic [sip_pkg::WordW-1:0] pending, pending_next;
  logic [sip_pkg::WordW-1:0] m, m_next;
  logic [2:0]                pos, pos_next;
  logic [7:0]                len, len_next;
  logic                      open, open_next;
  logic [sip_pkg::WordW-1:0] hash, hash_next;

  logic [sip_pkg::WordW-1:0] packed_word, final_word;
  logic [sip_pkg::WordW-1:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic [sip_pkg::WordW-1:0] v0_base, v1_base, v2_base, v3_base;

  assign status.word_full = byte_present && (pos == 3'd7);
  assign status.end_msg   = end_of_message;

  // Current word with the input byte placed at its position
  assign packed_word = pending
                     | ({{(sip_pkg::WordW-sip_pkg::ByteW){1'b0}}, message_byte} << {pos, 3'b000});
  assign final_word  = pending | {len, {(sip_pkg::WordW-8){1'b0}}};

  // State words as seen by an accepted byte: key-derived when a message opens
  assign v0_base = open ? v0 : (sip_pkg::SIP_C0 ^ key_low);
  assign v1_base = open ? v1 : (sip_pkg::SIP_C1 ^ key_high);
  assign v2_base = open ? v2 : (sip_pkg::SIP_C2 ^ key_low);
  assign v3_base = open ? v3 : (sip_pkg::SIP_C3 ^ key_high);

  // First half of a SipRound
  always_comb begin
    logic [sip_pkg::WordW-1:0] s0, s2;
    s0 = v0 + v1;
    s2 = v2 + v3;
    a1 = sip_pkg::rotl64(v1, 13) ^ s0;
    a3 = sip_pkg::rotl64(v3, 16) ^ s2;
    a0 = sip_pkg::rotl64(s0, 32);
    a2 = s2;
  end

  // Second half of a SipRound
  always_comb begin
    logic [sip_pkg::WordW-1:0] s0, s2;
    s2 = v2 + v1;
    s0 = v0 + v3;
    b1 = sip_pkg::rotl64(v1, 17) ^ s2;
    b3 = sip_pkg::rotl64(v3, 21) ^ s0;
    b2 = sip_pkg::rotl64(s2, 32);
    b0 = s0;
  end

  // Next values under the controller's command
  always_comb begin
    v0_next      = v0;
    v1_next      = v1;
    v2_next      = v2;
    v3_next      = v3;
    pending_next = pending;
    m_next       = m;
    pos_next     = pos;
    len_next     = len;
    open_next    = open;
    hash_next    = hash;

    if (cmd.accept) begin
      v0_next   = v0_base;
      v1_next   = v1_base;
      v2_next   = v2_base;
      v3_next   = v3_base;
      open_next = 1'b1;
      if (byte_present) begin
        pos_next = pos + 3'd1;
        len_next = len + 8'd1;
        if (pos == 3'd7) begin
          m_next       = packed_word;
          v3_next      = v3_base ^ packed_word;
          pending_next = '0;
        end else begin
          pending_next = packed_word;
        end
      end
    end

    if (cmd.half_round) begin
      v0_next = cmd.half_sel ? b0 : a0;
      v1_next = cmd.half_sel ? b1 : a1;
      v2_next = cmd.half_sel ? b2 : a2;
      v3_next = cmd.half_sel ? b3 : a3;
    end

    if (cmd.absorb_end) begin
      v0_next = v0 ^ m;
    end
    if (cmd.final_xor) begin
      v2_next = v2 ^ sip_pkg::SIP_FINAL_XOR;
    end

    if (cmd.final_load) begin
      m_next  = final_word;
      v3_next = v3 ^ final_word;
    end

    if (cmd.hash_load) begin
      hash_next    = v0 ^ v1 ^ v2 ^ v3;
      open_next    = 1'b0;
      pending_next = '0;
      pos_next     = '0;
      len_next     = '0;
    end
  end

  // Message bookkeeping (needs a clean start after reset)
  always_ff @(posedge clk) begin
    if (rst) begin
      open    <= 1'b0;
      pending <= '0;
      pos     <= '0;
      len     <= '0;
    end else begin
      open    <= open_next;
      pending <= pending_next;
      pos     <= pos_next;
      len     <= len_next;
    end
  end

  // Mixing state and output word
  always_ff @(posedge clk) begin
    v0   <= v0_next;
    v1   <= v1_next;
    v2   <= v2_next;
    v3   <= v3_next;
    m    <= m_next;
    hash <= hash_next;
  end

  assign hash_value = hash;

endmodule

// ===== rtl/core/siphash_keyed_hash.sv =====
`timescale 1ns / 1ps
// Top level of the SipHash keyed hash: configuration registers, controller
// and datapath. Depends on sip_pkg, sip_ctrl and sip_datapath.

// SipHash-c-d over a byte stream, one byte per input request (tuser marks
// the byte as present, tlast closes the message and yields a 64-bit hash
// on the output stream). The state is mixed by one half of a SipRound per
// cycle, set by the two dependent 64-bit adder levels of a full round.
// A byte that neither completes a word nor closes the message does not
// stall the input. The eighth byte of a word runs the c rounds; a closing
// request then also runs c rounds on the final word, then the d rounds.
// The hash sits in an output register, and a new message may start while
// it waits to be taken. Key and round counts are to be written through the
// cfg port while the block is idle, which the block does not enforce; the
// key is loaded into the state when a message opens.
module siphash_keyed_hash (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [sip_pkg::WordW-1:0] cfg_data,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [sip_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] message_byte
  input  logic                      s_axis_tuser,   // [0] byte_present
  input  logic                      s_axis_tlast,   // end_of_message
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [sip_pkg::WordW-1:0] m_axis_tdata    // [63:0] hash_value
);

  logic [sip_pkg::WordW-1:0]  key_low, key_high;
  logic [sip_pkg::RoundW-1:0] comp_rounds, fin_rounds;
  sip_pkg::sip_cmd_t          cmd;
  sip_pkg::sip_status_t       status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      comp_rounds <= sip_pkg::RoundW'(2);
      fin_rounds  <= sip_pkg::RoundW'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        sip_pkg::REG_KEY_LOW:   key_low     <= cfg_data;
        sip_pkg::REG_KEY_HIGH:  key_high    <= cfg_data;
        sip_pkg::REG_COMP_RNDS: comp_rounds <= cfg_data[sip_pkg::RoundW-1:0];
        sip_pkg::REG_FIN_RNDS:  fin_rounds  <= cfg_data[sip_pkg::RoundW-1:0];
        default: ;
      endcase
    end
  end

  sip_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .comp_rounds (comp_rounds),
    .fin_rounds  (fin_rounds),
    .status      (status),
    .cmd         (cmd)
  );

  sip_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .message_byte   (s_axis_tdata),
    .byte_present   (s_axis_tuser),
    .end_of_message (s_axis_tlast),
    .key_low        (key_low),
    .key_high       (key_high),
    .status         (status),
    .hash_value     (m_axis_tdata)
  );

endmodule

// ===== rtl/core/sip_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the SipHash keyed hash, bound to the top level.
// Depends on siphash_keyed_hash and sip_pkg.
module sip_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      s_axis_tuser,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [sip_pkg::WordW-1:0] m_axis_tdata
);

  // A held hash stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("hash changed or dropped while stalled");

  // Reset leaves the block ready with no hash pending
  a_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

  // A closing request always starts the finalisation rounds
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready after a closing request");

  // An empty non-closing request does not stall the input
  a_idle_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tlast |=> s_axis_tready)
    else $error("empty request stalled the input");

endmodule

bind siphash_keyed_hash sip_checker u_sip_checker (.*);

// ===== verif/siphash_keyed_hash_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for siphash_keyed_hash: directed table, then random messages
// under several key and round settings, each hash compared with a hand-typed value or an
// in-bench SipHash model. Depends on sip_pkg and the siphash_keyed_hash RTL.
module siphash_keyed_hash_tb;

  localparam int HALF_PERIOD    = 10;
  localparam int PHASE_REQUESTS = 150;
  localparam int SETTLE_CYCLES  = 120;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int LONG_MSG_LEN   = 260;

  // One input request as the block sees it
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       present;
    logic       last;
  } byte_req_t;

  // Directed row: request plus an optional hand-typed hash
  typedef struct packed {
    byte_req_t   req;
    logic        typed;
    logic [63:0] hash;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] message_byte
  logic        s_axis_tuser;   // [0] byte_present
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [63:0] hash_value

  // Model state: configuration copy and hash state
  logic [63:0] key_lo, key_hi;
  logic [3:0]  comp_rounds, fin_rounds;
  logic [63:0] hv0, hv1, hv2, hv3;
  logic [63:0] word_acc;
  logic [2:0]  byte_pos;
  logic [7:0]  msg_len;
  logic        msg_open;

  logic [63:0] hash_due_q [$];
  dir_row_t    dir_rows [$];
  int          fail_count = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_hold = 1'b0;
  bit          rx_hold_done = 1'b0;
  logic [63:0] hash_want;

  siphash_keyed_hash u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Hard limit on the run
  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  task automatic sip_round();
    hv0 = hv0 + hv1;
    hv2 = hv2 + hv3;
    hv1 = {hv1[50:0], hv1[63:51]};
    hv3 = {hv3[47:0], hv3[63:48]};
    hv1 = hv1 ^ hv0;
    hv3 = hv3 ^ hv2;
    hv0 = {hv0[31:0], hv0[63:32]};
    hv2 = hv2 + hv1;
    hv0 = hv0 + hv3;
    hv1 = {hv1[46:0], hv1[63:47]};
    hv3 = {hv3[42:0], hv3[63:43]};
    hv1 = hv1 ^ hv2;
    hv3 = hv3 ^ hv0;
    hv2 = {hv2[31:0], hv2[63:32]};
  endtask

  task automatic absorb_word(input logic [63:0] m);
    hv3 = hv3 ^ m;
    repeat (comp_rounds) sip_round();
    hv0 = hv0 ^ m;
  endtask

  task automatic close_message();
    hv0 = '0;
    hv1 = '0;
    hv2 = '0;
    hv3 = '0;
    word_acc = '0;
    byte_pos = '0;
    msg_len  = '0;
    msg_open = 1'b0;
  endtask

  // Advance the model by one request; got is set when a hash comes out
  task automatic sip_predict(input byte_req_t r, output bit got, output logic [63:0] h);
    got = 1'b0;
    h   = '0;
    // any request opens a message, loading the key as it stands now
    if (!msg_open) begin
      hv0 = sip_pkg::SIP_C0 ^ key_lo;
      hv1 = sip_pkg::SIP_C1 ^ key_hi;
      hv2 = sip_pkg::SIP_C2 ^ key_lo;
      hv3 = sip_pkg::SIP_C3 ^ key_hi;
      word_acc = '0;
      byte_pos = '0;
      msg_len  = '0;
      msg_open = 1'b1;
    end
    if (r.present) begin
      word_acc = word_acc | ({56'd0, r.msg_byte} << {byte_pos, 3'b000});
      msg_len  = msg_len + 8'd1;
      byte_pos = byte_pos + 3'd1;
      if (byte_pos == 3'd0) begin
        absorb_word(word_acc);
        word_acc = '0;
      end
    end
    if (r.last) begin
      absorb_word(word_acc | {msg_len, 56'd0});
      hv2 = hv2 ^ sip_pkg::SIP_FINAL_XOR;
      repeat (fin_rounds) sip_round();
      h   = hv0 ^ hv1 ^ hv2 ^ hv3;
      got = 1'b1;
      close_message();
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input sip_pkg::sip_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sip_pkg::REG_KEY_LOW:   key_lo = val;
      sip_pkg::REG_KEY_HIGH:  key_hi = val;
      sip_pkg::REG_COMP_RNDS: comp_rounds = val[3:0];
      sip_pkg::REG_FIN_RNDS:  fin_rounds = val[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [3:0] c, input logic [3:0] d);
    write_reg(sip_pkg::REG_KEY_LOW, k0);
    write_reg(sip_pkg::REG_KEY_HIGH, k1);
    write_reg(sip_pkg::REG_COMP_RNDS, {60'd0, c});
    write_reg(sip_pkg::REG_FIN_RNDS, {60'd0, d});
    cfg_we <= 1'b0;
  endtask

  // Offer one request; returns at the falling edge after it was taken
  task automatic feed_byte(input byte_req_t r, input bit typed, input logic [63:0] typed_hash);
    int          gap;
    bit          got;
    logic [63:0] h;
    gap = tx_gaps ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.msg_byte;
    s_axis_tuser  <= r.present;
    s_axis_tlast  <= r.last;
    do @(posedge clk); while (!s_axis_tready);
    sip_predict(r, got, h);
    if (got) hash_due_q.push_back(typed ? typed_hash : h);
    @(negedge clk);
  endtask

  task automatic feed_fields(input logic [7:0] b, input logic p, input logic l);
    byte_req_t r;
    r.msg_byte = b;
    r.present  = p;
    r.last     = l;
    feed_byte(r, 1'b0, '0);
  endtask

  // Stop offering, wait for every hash, then let the block finish its work
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hash_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic p, input logic l,
                         input logic typed, input logic [63:0] hash);
    dir_row_t row;
    row.req.msg_byte = b;
    row.req.present  = p;
    row.req.last     = l;
    row.typed        = typed;
    row.hash         = hash;
    dir_rows.push_back(row);
  endtask

  // One phase of random messages, mostly well formed, some noise
  task automatic random_phase(input int phase);
    int sent;
    int msg_no;
    int len;
    bit on_byte;
    sent   = 0;
    msg_no = 0;
    while (sent < PHASE_REQUESTS) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any combination of fields
        feed_fields(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        sent++;
      end else begin
        if (phase == 1 && msg_no == 2)
          len = LONG_MSG_LEN;
        else if ($urandom_range(0, 7) == 0)
          len = $urandom_range(17, 40);
        else
          len = $urandom_range(0, 16);
        on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            feed_fields(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            sent++;
          end
          feed_fields(8'($urandom_range(0, 255)), 1'b1, on_byte && (k == len - 1));
          sent++;
        end
        // empty closing request
        if (!on_byte) begin
          feed_fields(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          sent++;
        end
        msg_no++;
      end
    end
    // odd phases leave a message open, across the next register writes where one follows
    if (phase % 2 == 1) begin
      for (int k = 0; k < 3; k++) feed_fields(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    m_axis_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rx_hold && !rx_hold_done) begin
        // long hold-off so that the block backs up into its input
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (1 + gap_len()) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Compare each hash taken with the oldest one due
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hash_due_q.size() == 0) begin
        $error("hash_value: unexpected result %h", m_axis_tdata);
        fail_count++;
      end else begin
        hash_want = hash_due_q.pop_front();
        if (m_axis_tdata !== hash_want) begin
          $error("hash_value: expected %h, actual %h", hash_want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = sip_pkg::REG_KEY_LOW;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    key_lo        = '0;
    key_hi        = '0;
    comp_rounds   = 4'd2;
    fin_rounds    = 4'd4;
    close_message();

    // Directed table, standard SipHash-2-4 key 00..0f
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31);  // empty message
    for (int i = 0; i < 15; i++)                            // 15-byte message 00..0e
      add_row(i[7:0], 1'b1, i == 14, i == 14, 64'ha129ca6149be45e5);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);  // idle request opens a message
    add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);  // empty close after one byte
    add_row(8'h80, 1'b1, 1'b1, 1'b0, '0);  // single byte closing itself

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 4'd2, 4'd4);
    tx_gaps = 1'b1;
    foreach (dir_rows[i]) feed_byte(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].hash);
    drain();

    // Random phases over a spread of keys and round counts
    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: set_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd2, 4'd4);
        2: set_config({64{1'b1}}, {64{1'b1}}, 4'd0, 4'd0);
        3: set_config('0, '0, 4'd15, 4'd15);
        4: set_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd1, 4'd3);
        default: set_config({$urandom, $urandom}, {$urandom, $urandom},
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      if (phase == 1) rx_hold = 1'b1;
      random_phase(phase);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
